// ----- hdl/pict_pkg.sv -----
// ============================================================================
// pict_pkg - shared widths for the point-in-capped-cylinder test
// Field, product and quotient widths used by the channels and the datapath.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package pict_pkg;

    localparam int COORD_W    = 24;               // signed coordinate
    localparam int SQ_W       = 48;               // squared length / radius
    localparam int DIFF_W     = COORD_W + 1;      // coordinate difference
    localparam int PROD_W     = 2 * DIFF_W;       // full signed product
    localparam int DOT_W      = PROD_W + 1;       // dot product, signed
    localparam int PP_W       = SQ_W + 2;         // sum of three squares
    localparam int QUOT_W     = SQ_W;             // dot^2 / lsq, never above lsq
    localparam int REM_W      = SQ_W;             // remainder, below lsq
    localparam int PART_W     = REM_W + 2;        // 2r + a, below 3 * 2^48
    localparam int DIV_STAGES = SQ_W;             // one dot bit per stage

endpackage : pict_pkg

`default_nettype wire

// ----- hdl/pict_if.sv -----
// ============================================================================
// pict_if - channels of the point-in-capped-cylinder test
// Probe request, test result and radius write channels, valid/ready each.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface pict_req_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [pict_pkg::COORD_W-1:0]    axis_start_x;
    logic signed [pict_pkg::COORD_W-1:0]    axis_start_y;
    logic signed [pict_pkg::COORD_W-1:0]    axis_start_z;
    logic signed [pict_pkg::COORD_W-1:0]    axis_end_x;
    logic signed [pict_pkg::COORD_W-1:0]    axis_end_y;
    logic signed [pict_pkg::COORD_W-1:0]    axis_end_z;
    logic        [pict_pkg::SQ_W-1:0]       axis_length_squared;
    logic signed [pict_pkg::COORD_W-1:0]    probe_x;
    logic signed [pict_pkg::COORD_W-1:0]    probe_y;
    logic signed [pict_pkg::COORD_W-1:0]    probe_z;

    modport source (
        output valid, axis_start_x, axis_start_y, axis_start_z,
               axis_end_x, axis_end_y, axis_end_z, axis_length_squared,
               probe_x, probe_y, probe_z,
        input  ready
    );
    modport sink (
        input  valid, axis_start_x, axis_start_y, axis_start_z,
               axis_end_x, axis_end_y, axis_end_z, axis_length_squared,
               probe_x, probe_y, probe_z,
        output ready
    );
endinterface : pict_req_if

interface pict_res_if;
    logic                           valid;
    logic                           ready;
    logic                           inside_res;
    logic [pict_pkg::SQ_W-1:0]      axis_distance_squared;

    modport source (output valid, inside_res, axis_distance_squared, input ready);
    modport sink   (input valid, inside_res, axis_distance_squared, output ready);
endinterface : pict_res_if

interface pict_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pict_pkg::SQ_W-1:0]      data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface : pict_cfg_if

`default_nettype wire

// ----- hdl/point_in_cylinder_test.sv -----
// ============================================================================
// point_in_cylinder_test - streaming point-in-capped-cylinder test
// Projects a probe onto an axis segment, checks the end caps, and compares
// the squared distance to the axis against the programmed squared radius.
// ============================================================================
// Pipeline: 5 front stages, 48 quotient stages, 1 final stage, then the output
//   register; an item accepted on req passes through all of them to reach res.
// Throughput: one item per cycle while the skid register is empty; the 48-stage
//   quotient pipeline retires one bit of dot per stage, so each stage takes a new item whenever the pipeline advances.
// Reset: rst_n clears all valid bits, the skid flag and radius_reg (0).
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module point_in_cylinder_test (
    input  wire         clk,
    input  wire         rst_n,
    pict_req_if.sink    req,
    pict_res_if.source  res,
    pict_cfg_if.sink    cfg
);

    // ------------------------------------------------------------------
    // Radius register. The user must write it only while the block is idle;
    // the block does not enforce this, and the final compare reads it directly.
    // ------------------------------------------------------------------
    logic [pict_pkg::SQ_W-1:0] radius_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= '0;
        else if (cfg.valid)
            radius_reg <= cfg.data;
    end

    // ------------------------------------------------------------------
    // Pipeline enable. All stages advance together; the skid register at
    // the output absorbs the one item that lands while res is stalled, so
    // req.ready comes straight from a flop.
    // ------------------------------------------------------------------
    logic skid_valid_reg;
    logic en;

    assign en        = !skid_valid_reg;
    assign req.ready = en;

    // ------------------------------------------------------------------
    // Stage 1: axis vector d = E - S and probe vector q = P - S.
    // ------------------------------------------------------------------
    logic                                   s1_valid_reg;
    logic signed [pict_pkg::DIFF_W-1:0]     s1_dx_reg, s1_dy_reg, s1_dz_reg;
    logic signed [pict_pkg::DIFF_W-1:0]     s1_qx_reg, s1_qy_reg, s1_qz_reg;
    logic        [pict_pkg::SQ_W-1:0]       s1_lsq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dx_reg  <= pict_pkg::DIFF_W'(req.axis_end_x) -
                          pict_pkg::DIFF_W'(req.axis_start_x);
            s1_dy_reg  <= pict_pkg::DIFF_W'(req.axis_end_y) -
                          pict_pkg::DIFF_W'(req.axis_start_y);
            s1_dz_reg  <= pict_pkg::DIFF_W'(req.axis_end_z) -
                          pict_pkg::DIFF_W'(req.axis_start_z);
            s1_qx_reg  <= pict_pkg::DIFF_W'(req.probe_x) -
                          pict_pkg::DIFF_W'(req.axis_start_x);
            s1_qy_reg  <= pict_pkg::DIFF_W'(req.probe_y) -
                          pict_pkg::DIFF_W'(req.axis_start_y);
            s1_qz_reg  <= pict_pkg::DIFF_W'(req.probe_z) -
                          pict_pkg::DIFF_W'(req.axis_start_z);
            s1_lsq_reg <= req.axis_length_squared;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: six 25x25 products, one multiplier each. Squares of a
    // 25-bit difference stay below 2^48, so keep only the low bits.
    // ------------------------------------------------------------------
    logic signed [pict_pkg::PROD_W-1:0]     sqx_full, sqy_full, sqz_full;
    logic                                   s2_valid_reg;
    logic signed [pict_pkg::PROD_W-1:0]     s2_pdx_reg, s2_pdy_reg, s2_pdz_reg;
    logic        [pict_pkg::SQ_W-1:0]       s2_sqx_reg, s2_sqy_reg, s2_sqz_reg;
    logic        [pict_pkg::SQ_W-1:0]       s2_lsq_reg;

    always_comb
    begin
        sqx_full = pict_pkg::PROD_W'(s1_qx_reg) * pict_pkg::PROD_W'(s1_qx_reg);
        sqy_full = pict_pkg::PROD_W'(s1_qy_reg) * pict_pkg::PROD_W'(s1_qy_reg);
        sqz_full = pict_pkg::PROD_W'(s1_qz_reg) * pict_pkg::PROD_W'(s1_qz_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_pdx_reg <= pict_pkg::PROD_W'(s1_qx_reg) * pict_pkg::PROD_W'(s1_dx_reg);
            s2_pdy_reg <= pict_pkg::PROD_W'(s1_qy_reg) * pict_pkg::PROD_W'(s1_dy_reg);
            s2_pdz_reg <= pict_pkg::PROD_W'(s1_qz_reg) * pict_pkg::PROD_W'(s1_dz_reg);
            s2_sqx_reg <= sqx_full[pict_pkg::SQ_W-1:0];
            s2_sqy_reg <= sqy_full[pict_pkg::SQ_W-1:0];
            s2_sqz_reg <= sqz_full[pict_pkg::SQ_W-1:0];
            s2_lsq_reg <= s1_lsq_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: first pair of each three-term sum; carry the third term.
    // ------------------------------------------------------------------
    logic                                   s3_valid_reg;
    logic signed [pict_pkg::DOT_W-1:0]      s3_dot_ab_reg;
    logic signed [pict_pkg::PROD_W-1:0]     s3_pdz_reg;
    logic        [pict_pkg::SQ_W:0]         s3_pp_ab_reg;
    logic        [pict_pkg::SQ_W-1:0]       s3_sqz_reg;
    logic        [pict_pkg::SQ_W-1:0]       s3_lsq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (en)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_dot_ab_reg <= pict_pkg::DOT_W'(s2_pdx_reg) + pict_pkg::DOT_W'(s2_pdy_reg);
            s3_pdz_reg    <= s2_pdz_reg;
            s3_pp_ab_reg  <= {1'b0, s2_sqx_reg} + {1'b0, s2_sqy_reg};
            s3_sqz_reg    <= s2_sqz_reg;
            s3_lsq_reg    <= s2_lsq_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: finish dot = q.d and pp = q.q.
    // ------------------------------------------------------------------
    logic                                   s4_valid_reg;
    logic signed [pict_pkg::DOT_W-1:0]      s4_dot_reg;
    logic        [pict_pkg::PP_W-1:0]       s4_pp_reg;
    logic        [pict_pkg::SQ_W-1:0]       s4_lsq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (en)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_dot_reg <= s3_dot_ab_reg + pict_pkg::DOT_W'(s3_pdz_reg);
            s4_pp_reg  <= pict_pkg::PP_W'(s3_pp_ab_reg) + pict_pkg::PP_W'(s3_sqz_reg);
            s4_lsq_reg <= s3_lsq_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: end-cap test. A probe behind the start cap has a negative
    // dot; one beyond the end cap has dot above lsq. When it passes, dot
    // lies in 0..lsq and fits 48 bits, which seeds the quotient pipeline.
    // Index 0 of the dv_* arrays is this stage.
    // ------------------------------------------------------------------
    logic                                   cap_out;
    logic                                   dv_valid_reg   [0:pict_pkg::DIV_STAGES];
    logic                                   dv_outside_reg [0:pict_pkg::DIV_STAGES];
    logic                                   dv_lzero_reg   [0:pict_pkg::DIV_STAGES];
    logic [pict_pkg::SQ_W-1:0]              dv_a_reg       [0:pict_pkg::DIV_STAGES];
    logic [pict_pkg::SQ_W-1:0]              dv_l_reg       [0:pict_pkg::DIV_STAGES];
    logic [pict_pkg::REM_W-1:0]             dv_r_reg       [0:pict_pkg::DIV_STAGES];
    logic [pict_pkg::QUOT_W-1:0]            dv_q_reg       [0:pict_pkg::DIV_STAGES];
    logic [pict_pkg::PP_W-1:0]              dv_pp_reg      [0:pict_pkg::DIV_STAGES];

    assign cap_out = s4_dot_reg[pict_pkg::DOT_W-1] ||
                     ($unsigned(s4_dot_reg) > pict_pkg::DOT_W'(s4_lsq_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else if (en)
            dv_valid_reg[0] <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_outside_reg[0] <= cap_out;
            dv_lzero_reg[0]   <= (s4_lsq_reg == '0);
            dv_a_reg[0]       <= s4_dot_reg[pict_pkg::SQ_W-1:0];
            dv_l_reg[0]       <= s4_lsq_reg;
            dv_r_reg[0]       <= '0;
            dv_q_reg[0]       <= '0;
            dv_pp_reg[0]      <= s4_pp_reg;
        end
    end

    // ------------------------------------------------------------------
    // Quotient pipeline: floor(a*a / l) without a wide product. Walking a
    // from its top bit, each stage doubles the remainder, adds a when the
    // bit is set, and takes out l at most twice (2r + a < 3l since r < l
    // and a <= l). The quotient gains one digit of 0, 1 or 2 per stage.
    // With l = 0 the digits are garbage; the final stage drops them.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < pict_pkg::DIV_STAGES; k++)
    begin : g_div
        localparam int BIT = pict_pkg::DIV_STAGES - 1 - k;

        logic [pict_pkg::PART_W-1:0]    part;
        logic [pict_pkg::PART_W-1:0]    lim1;
        logic [pict_pkg::PART_W-1:0]    lim2;
        logic [1:0]                     digit;
        logic [pict_pkg::REM_W-1:0]     rem_next;
        logic [pict_pkg::QUOT_W-1:0]    quot_next;

        always_comb
        begin
            part = {1'b0, dv_r_reg[k], 1'b0} +
                   (dv_a_reg[k][BIT] ? pict_pkg::PART_W'(dv_a_reg[k])
                                     : {pict_pkg::PART_W{1'b0}});
            lim1 = pict_pkg::PART_W'(dv_l_reg[k]);
            lim2 = {1'b0, dv_l_reg[k], 1'b0};
            if (part >= lim2)
            begin
                digit    = 2'd2;
                rem_next = pict_pkg::REM_W'(part - lim2);
            end
            else if (part >= lim1)
            begin
                digit    = 2'd1;
                rem_next = pict_pkg::REM_W'(part - lim1);
            end
            else
            begin
                digit    = 2'd0;
                rem_next = part[pict_pkg::REM_W-1:0];
            end
            quot_next = {dv_q_reg[k][pict_pkg::QUOT_W-2:0], 1'b0} +
                        pict_pkg::QUOT_W'(digit);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[k+1] <= 1'b0;
            else if (en)
                dv_valid_reg[k+1] <= dv_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_outside_reg[k+1] <= dv_outside_reg[k];
                dv_lzero_reg[k+1]   <= dv_lzero_reg[k];
                dv_a_reg[k+1]       <= dv_a_reg[k];
                dv_l_reg[k+1]       <= dv_l_reg[k];
                dv_r_reg[k+1]       <= rem_next;
                dv_q_reg[k+1]       <= quot_next;
                dv_pp_reg[k+1]      <= dv_pp_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Final stage: distance = pp - quotient, zero quotient for a zero-length
    // axis, clamp negative results (inconsistent lsq) to zero.
    // ------------------------------------------------------------------
    localparam int LAST = pict_pkg::DIV_STAGES;

    logic [pict_pkg::QUOT_W-1:0]            quot_eff;
    logic signed [pict_pkg::DOT_W-1:0]      dist_diff;
    logic                                   f1_valid_reg;
    logic                                   f1_outside_reg;
    logic [pict_pkg::PP_W-1:0]              f1_dist_reg;

    always_comb
    begin
        quot_eff  = dv_lzero_reg[LAST] ? '0 : dv_q_reg[LAST];
        dist_diff = $signed({1'b0, dv_pp_reg[LAST]}) -
                    $signed(pict_pkg::DOT_W'(quot_eff));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f1_valid_reg <= 1'b0;
        else if (en)
            f1_valid_reg <= dv_valid_reg[LAST];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_outside_reg <= dv_outside_reg[LAST];
            f1_dist_reg    <= dist_diff[pict_pkg::DOT_W-1] ? '0
                                                           : dist_diff[pict_pkg::PP_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Radius compare feeds the output register or the skid register.
    // A distance above the radius, or a failed cap test, reports outside
    // with a zero distance.
    // ------------------------------------------------------------------
    logic                           push;
    logic                           hit_inside;
    logic [pict_pkg::SQ_W-1:0]      hit_dist;
    logic                           out_valid_reg;
    logic                           out_inside_reg;
    logic [pict_pkg::SQ_W-1:0]      out_dist_reg;
    logic                           skid_inside_reg;
    logic [pict_pkg::SQ_W-1:0]      skid_dist_reg;
    logic                           out_free;

    always_comb
    begin
        push       = en && f1_valid_reg;
        hit_inside = !f1_outside_reg &&
                     (f1_dist_reg <= pict_pkg::PP_W'(radius_reg));
        hit_dist   = hit_inside ? f1_dist_reg[pict_pkg::SQ_W-1:0] : '0;
        out_free   = !out_valid_reg || res.ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            // drain the skid first; the pipeline is frozen while it is full
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_inside_reg <= skid_inside_reg;
                out_dist_reg   <= skid_dist_reg;
            end
            else
            begin
                out_inside_reg <= hit_inside;
                out_dist_reg   <= hit_dist;
            end
        end
        else if (push)
        begin
            skid_inside_reg <= hit_inside;
            skid_dist_reg   <= hit_dist;
        end
    end

    assign res.valid                 = out_valid_reg;
    assign res.inside_res            = out_inside_reg;
    assign res.axis_distance_squared = out_dist_reg;

endmodule : point_in_cylinder_test

`default_nettype wire

// ----- hdl/pict_checker.sv -----
// ============================================================================
// pict_checker - port-level checks for point_in_cylinder_test
// Watches the result channel and the radius writes over time.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module pict_checker (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cfg_valid,
    input  wire                             cfg_ready,
    input  wire [pict_pkg::SQ_W-1:0]        cfg_data,
    input  wire                             res_valid,
    input  wire                             res_ready,
    input  wire                             res_inside,
    input  wire [pict_pkg::SQ_W-1:0]        res_dist
);

    // track the programmed radius from the write channel
    logic [pict_pkg::SQ_W-1:0] radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= '0;
        else if (cfg_valid && cfg_ready)
            radius_reg <= cfg_data;
    end

    a_res_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result item dropped while stalled");

    a_res_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_inside) && $stable(res_dist))
        else $error("result item changed while stalled");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_inside |-> res_dist == '0)
        else $error("outside result carries a nonzero distance");

    a_inside_radius: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_inside |-> res_dist <= radius_reg)
        else $error("inside result beyond the programmed radius");

endmodule : pict_checker

bind point_in_cylinder_test pict_checker u_pict_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg.valid),
    .cfg_ready  (cfg.ready),
    .cfg_data   (cfg.data),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_inside (res.inside_res),
    .res_dist   (res.axis_distance_squared)
);

`default_nettype wire
